FILE: hw/rtl/bayq_pkg.sv
// bayq_pkg: shared types, register indexes and constants of the block average
// YCoCg quantizer. No dependencies; used by every module of the block but bayq_queue.
package bayq_pkg;

  // default pixel capacity of one block
  localparam int MAX_BLOCK_PIXELS_DEF = 256;

  // 4*255: full scale of the integer luma term R+2G+B per pixel
  localparam int LUMA_SCALE = 1020;
  // bias added to each doubled chroma term so the per-pixel sum stays unsigned
  localparam int CHROMA_BIAS = 1020;

  // per-pixel term widths: luma up to 1020, biased chroma up to 2040
  localparam int LTERM_W = 10;
  localparam int CTERM_W = 11;

  // quotient bits: every level is at most 510
  localparam int Q_W    = 9;
  localparam int STEP_W = $clog2(Q_W);

  // register file
  localparam int PADDR_W = 4;
  localparam int REG_W   = 8;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_LUMA_RANGE   = 2'd0,
    REG_ORANGE_RANGE = 2'd1,
    REG_GREEN_RANGE  = 2'd2
  } reg_idx_t;

  localparam logic [REG_W-1:0] RANGE_RESET = 8'd255;

  typedef struct packed {
    logic [REG_W-1:0] luma_range;
    logic [REG_W-1:0] orange_range;
    logic [REG_W-1:0] green_range;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] block_column;
    logic [9:0] block_row;
    logic       last_of_block;
  } in_t;

  typedef struct packed {
    logic [9:0] out_column;
    logic [9:0] out_row;
    logic [7:0] luma_level;
    logic [8:0] orange_level;
    logic [8:0] green_level;
  } out_t;

endpackage

FILE: hw/rtl/bayq_front.sv
// bayq_front: per-pixel accumulation of luma and biased chroma sums and the
// pixel count; hands a finished block to the job queue. Uses bayq_pkg.
module bayq_front #(
  parameter int MAX_BLOCK_PIXELS = bayq_pkg::MAX_BLOCK_PIXELS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  input  bayq_pkg::in_t                            in_data,
  output logic                                     in_ready,
  output logic                                     push_valid,
  input  logic                                     push_ready,
  output logic [$clog2(1020*MAX_BLOCK_PIXELS+1)-1:0] job_lsum,
  output logic [$clog2(2040*MAX_BLOCK_PIXELS+1)-1:0] job_osum,
  output logic [$clog2(2040*MAX_BLOCK_PIXELS+1)-1:0] job_gsum,
  output logic [$clog2(MAX_BLOCK_PIXELS+1)-1:0]      job_cnt,
  output logic [9:0]                               job_col,
  output logic [9:0]                               job_row
);

  localparam int CNT_W  = $clog2(MAX_BLOCK_PIXELS + 1);
  localparam int LSUM_W = $clog2(1020 * MAX_BLOCK_PIXELS + 1);
  localparam int TSUM_W = $clog2(2040 * MAX_BLOCK_PIXELS + 1);

  logic [LSUM_W-1:0] lsum_r;
  logic [TSUM_W-1:0] osum_r, gsum_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [bayq_pkg::LTERM_W-1:0] luma_term;
  logic [bayq_pkg::CTERM_W-1:0] orange_term, green_term;
  logic [LSUM_W-1:0] lsum_nxt;
  logic [TSUM_W-1:0] osum_nxt, gsum_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              room, accept;

  // per-pixel terms: R+2G+B, 4R-4B+bias, 4G-2R-2B+bias (all non-negative)
  always_comb begin
    luma_term   = bayq_pkg::LTERM_W'(in_data.red) + {1'b0, in_data.green, 1'b0}
                + bayq_pkg::LTERM_W'(in_data.blue);
    orange_term = {1'b0, in_data.red, 2'b00}
                + bayq_pkg::CTERM_W'(bayq_pkg::CHROMA_BIAS)
                - {1'b0, in_data.blue, 2'b00};
    green_term  = {1'b0, in_data.green, 2'b00}
                + bayq_pkg::CTERM_W'(bayq_pkg::CHROMA_BIAS)
                - {2'b00, in_data.red, 1'b0} - {2'b00, in_data.blue, 1'b0};
  end

  // pixels beyond the capacity are dropped
  always_comb begin
    room = cnt_r < CNT_W'(MAX_BLOCK_PIXELS);
    if (room) begin
      lsum_nxt = lsum_r + LSUM_W'(luma_term);
      osum_nxt = osum_r + TSUM_W'(orange_term);
      gsum_nxt = gsum_r + TSUM_W'(green_term);
      cnt_nxt  = cnt_r + CNT_W'(1);
    end else begin
      lsum_nxt = lsum_r;
      osum_nxt = osum_r;
      gsum_nxt = gsum_r;
      cnt_nxt  = cnt_r;
    end
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && in_data.last_of_block;

  assign job_lsum = lsum_nxt;
  assign job_osum = osum_nxt;
  assign job_gsum = gsum_nxt;
  assign job_cnt  = cnt_nxt;
  assign job_col  = in_data.block_column;
  assign job_row  = in_data.block_row;

  // accumulators, cleared at the end of each block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsum_r <= '0;
      osum_r <= '0;
      gsum_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      if (in_data.last_of_block) begin
        lsum_r <= '0;
        osum_r <= '0;
        gsum_r <= '0;
        cnt_r  <= '0;
      end else begin
        lsum_r <= lsum_nxt;
        osum_r <= osum_nxt;
        gsum_r <= gsum_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule

FILE: hw/rtl/bayq_queue.sv
// bayq_queue: small register FIFO carrying finished block jobs from the
// front to the back. No package dependencies.
module bayq_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wrap_inc(wptr_r);
      if (do_pop)  rptr_r <= wrap_inc(rptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

FILE: hw/rtl/bayq_back.sv
// bayq_back: per-block scaling and restoring division with round-half-even,
// plus the result register. Uses bayq_pkg.
module bayq_back #(
  parameter int MAX_BLOCK_PIXELS = bayq_pkg::MAX_BLOCK_PIXELS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  bayq_pkg::cfg_t                             cfg,
  input  logic                                       job_valid,
  output logic                                       job_ready,
  input  logic [$clog2(1020*MAX_BLOCK_PIXELS+1)-1:0] job_lsum,
  input  logic [$clog2(2040*MAX_BLOCK_PIXELS+1)-1:0] job_osum,
  input  logic [$clog2(2040*MAX_BLOCK_PIXELS+1)-1:0] job_gsum,
  input  logic [$clog2(MAX_BLOCK_PIXELS+1)-1:0]      job_cnt,
  input  logic [9:0]                                 job_col,
  input  logic [9:0]                                 job_row,
  output logic                                       out_valid,
  output bayq_pkg::out_t                             out_data,
  input  logic                                       out_ready
);

  localparam int LSUM_W = $clog2(1020 * MAX_BLOCK_PIXELS + 1);
  localparam int TSUM_W = $clog2(2040 * MAX_BLOCK_PIXELS + 1);
  localparam int DEN_W  = LSUM_W;
  localparam int CMP_W  = DEN_W + bayq_pkg::Q_W;
  localparam int Q_W    = bayq_pkg::Q_W;
  localparam int STEP_W = bayq_pkg::STEP_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t             state_r;
  logic [STEP_W-1:0]  step_r;
  logic [CMP_W-1:0]   rem_l_r, rem_o_r, rem_g_r, d_r;
  logic [DEN_W-1:0]   den_r;
  logic [Q_W-1:0]     q_l_r, q_o_r, q_g_r;
  logic [9:0]         col_r, row_r;
  logic               out_valid_r;
  bayq_pkg::out_t     out_data_r;

  logic [LSUM_W+7:0]  prod_l;
  logic [TSUM_W+7:0]  prod_o, prod_g;
  logic [DEN_W-1:0]   den_w;
  logic               ge_l, ge_o, ge_g, out_free;
  logic [Q_W-1:0]     lvl_l, lvl_o, lvl_g;

  // numerators and divisor, formed as the job is taken
  assign prod_l = job_lsum * cfg.luma_range;
  assign prod_o = job_osum * cfg.orange_range;
  assign prod_g = job_gsum * cfg.green_range;
  assign den_w  = DEN_W'(job_cnt * bayq_pkg::LUMA_SCALE);

  assign job_ready = state_r == S_IDLE;
  assign out_free  = !out_valid_r || out_ready;

  // one quotient bit per cycle for each channel
  assign ge_l = rem_l_r >= d_r;
  assign ge_o = rem_o_r >= d_r;
  assign ge_g = rem_g_r >= d_r;

  // round to nearest, ties to even; remainder is below the divisor
  function automatic logic [Q_W-1:0] round_even(input logic [Q_W-1:0]   q,
                                                input logic [CMP_W-1:0] rem,
                                                input logic [DEN_W-1:0] den);
    logic [DEN_W:0] twice_r;
    logic           up;
    twice_r = {rem[DEN_W-1:0], 1'b0};
    up = (twice_r > {1'b0, den}) || ((twice_r == {1'b0, den}) && q[0]);
    return q + Q_W'(up);
  endfunction

  assign lvl_l = round_even(q_l_r, rem_l_r, den_r);
  assign lvl_o = round_even(q_o_r, rem_o_r, den_r);
  assign lvl_g = round_even(q_g_r, rem_g_r, den_r);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: loaded with the rounded levels, emptied on handshake
      if (state_r == S_DONE && out_free)  out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready)  out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            state_r <= S_DIV;
            step_r  <= '0;
          end
        end
        S_DIV: begin
          if (step_r == STEP_W'(Q_W - 1)) state_r <= S_DONE;
          step_r <= step_r + STEP_W'(1);
        end
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          rem_l_r <= CMP_W'(prod_l);
          rem_o_r <= CMP_W'(prod_o);
          rem_g_r <= CMP_W'(prod_g);
          d_r     <= CMP_W'(den_w) << (Q_W - 1);
          den_r   <= den_w;
          q_l_r   <= '0;
          q_o_r   <= '0;
          q_g_r   <= '0;
          col_r   <= job_col;
          row_r   <= job_row;
        end
      end
      S_DIV: begin
        if (ge_l) rem_l_r <= rem_l_r - d_r;
        if (ge_o) rem_o_r <= rem_o_r - d_r;
        if (ge_g) rem_g_r <= rem_g_r - d_r;
        q_l_r <= {q_l_r[Q_W-2:0], ge_l};
        q_o_r <= {q_o_r[Q_W-2:0], ge_o};
        q_g_r <= {q_g_r[Q_W-2:0], ge_g};
        d_r   <= d_r >> 1;
      end
      S_DONE: begin
        if (out_free) begin
          out_data_r.out_column   <= col_r;
          out_data_r.out_row      <= row_r;
          out_data_r.luma_level   <= lvl_l[7:0];
          out_data_r.orange_level <= lvl_o;
          out_data_r.green_level  <= lvl_g;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/block_average_ycocg_quantizer_core.sv
// block_average_ycocg_quantizer_core: top level with the APB register file,
// front accumulator, job queue and back divider. Uses bayq_pkg, bayq_front,
// bayq_queue and bayq_back.
// Pixels of one block are accepted at one per cycle, in any order, while the
// job queue has room; the pixel flagged last_of_block closes the block and
// queues a job holding the luma and biased chroma sums, the pixel count and
// the grid position. The back stage scales the sums by the range registers
// as it takes a job, runs nine restoring divide steps shared by the three
// channels, then rounds and loads the result register; it takes no new job
// before the last is through. A two-entry job queue absorbs short blocks,
// after which the input waits on the divider. Pixels beyond MAX_BLOCK_PIXELS
// in one block are dropped. Range registers (luma 0x0, orange 0x4, green 0x8,
// reset 255) are to be written only while the block is idle.
module block_average_ycocg_quantizer_core #(
  parameter int MAX_BLOCK_PIXELS = bayq_pkg::MAX_BLOCK_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  bayq_pkg::in_t                  in_data,
  output logic                           in_ready,
  output logic                           out_valid,
  output bayq_pkg::out_t                 out_data,
  input  logic                           out_ready,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bayq_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [bayq_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [bayq_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                           cfg_pready
);

  localparam int CNT_W  = $clog2(MAX_BLOCK_PIXELS + 1);
  localparam int LSUM_W = $clog2(1020 * MAX_BLOCK_PIXELS + 1);
  localparam int TSUM_W = $clog2(2040 * MAX_BLOCK_PIXELS + 1);
  localparam int JOB_W  = 20 + CNT_W + 2 * TSUM_W + LSUM_W;
  localparam int QDEPTH = 2;

  bayq_pkg::cfg_t    cfg_r;
  bayq_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  logic              push_valid, push_ready, pop_valid, pop_ready;
  logic [JOB_W-1:0]  push_data, pop_data;
  logic [LSUM_W-1:0] f_lsum, b_lsum;
  logic [TSUM_W-1:0] f_osum, f_gsum, b_osum, b_gsum;
  logic [CNT_W-1:0]  f_cnt, b_cnt;
  logic [9:0]        f_col, f_row, b_col, b_row;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = bayq_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.luma_range   <= bayq_pkg::RANGE_RESET;
      cfg_r.orange_range <= bayq_pkg::RANGE_RESET;
      cfg_r.green_range  <= bayq_pkg::RANGE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        bayq_pkg::REG_LUMA_RANGE:   cfg_r.luma_range   <= cfg_pwdata[7:0];
        bayq_pkg::REG_ORANGE_RANGE: cfg_r.orange_range <= cfg_pwdata[7:0];
        bayq_pkg::REG_GREEN_RANGE:  cfg_r.green_range  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (reg_idx)
      bayq_pkg::REG_LUMA_RANGE:   cfg_prdata = bayq_pkg::PDATA_W'(cfg_r.luma_range);
      bayq_pkg::REG_ORANGE_RANGE: cfg_prdata = bayq_pkg::PDATA_W'(cfg_r.orange_range);
      bayq_pkg::REG_GREEN_RANGE:  cfg_prdata = bayq_pkg::PDATA_W'(cfg_r.green_range);
      default:                    cfg_prdata = '0;
    endcase
  end

  // front: accumulation
  bayq_front #(.MAX_BLOCK_PIXELS(MAX_BLOCK_PIXELS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .job_lsum   (f_lsum),
    .job_osum   (f_osum),
    .job_gsum   (f_gsum),
    .job_cnt    (f_cnt),
    .job_col    (f_col),
    .job_row    (f_row)
  );

  // job queue
  assign push_data = {f_col, f_row, f_cnt, f_gsum, f_osum, f_lsum};
  assign {b_col, b_row, b_cnt, b_gsum, b_osum, b_lsum} = pop_data;

  bayq_queue #(.WIDTH(JOB_W), .DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // back: scaling, division and result register
  bayq_back #(.MAX_BLOCK_PIXELS(MAX_BLOCK_PIXELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .job_valid  (pop_valid),
    .job_ready  (pop_ready),
    .job_lsum   (b_lsum),
    .job_osum   (b_osum),
    .job_gsum   (b_gsum),
    .job_cnt    (b_cnt),
    .job_col    (b_col),
    .job_row    (b_row),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ready)
  );

endmodule

FILE: hw/rtl/bayq_checker.sv
// bayq_checker: port-level assertions for the block average YCoCg quantizer,
// bound to the top level. Uses bayq_pkg.
module bayq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input bayq_pkg::out_t out_data,
  input logic           out_ready
);

  // a stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // reset empties the job queue, so pixels are taken at once
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // chroma levels never exceed twice the largest range
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.orange_level <= 9'd510) && (out_data.green_level <= 9'd510))
    else $error("chroma level out of range");

endmodule

bind block_average_ycocg_quantizer_core bayq_checker u_bayq_checker (.*);
